// File: hw/rtl/scfla_pkg.sv
// Shared types, constants and the size class function for the size class allocator.
// No dependencies; imported by every module of the block.
package scfla_pkg;

   localparam int unsigned SIZE_W        = 16;
   localparam int unsigned ADDR_W        = 20;
   localparam int unsigned GRANULE_W     = 16;
   localparam int unsigned GRANT_W       = 12;
   localparam int unsigned OFFSET_W      = 21;
   localparam int unsigned NUM_CLASSES   = 8;
   localparam int unsigned CLASS_W       = 3;
   localparam int unsigned MAX_SMALL     = 2048;
   localparam int unsigned CLASS_MIN     = 16;
   localparam int unsigned ADDR_SPACE    = 1 << ADDR_W;
   localparam int unsigned ARENA_DEFAULT = 1048576;
   localparam int unsigned ARENA_RESET   = 1048576;

   localparam logic FUNC_ALLOC = 1'b0;
   localparam logic FUNC_FREE  = 1'b1;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_OUT_OF_MEM = 2'd1,
      ST_TOO_LARGE = 2'd2
   } status_type;

   typedef enum logic {
      S_IDLE,
      S_EXEC
   } state_type;

   // One free list link: a valid flag and a 16-byte granule number.
   typedef struct packed {
      logic                 valid;
      logic [GRANULE_W-1:0] granule;
   } link_type;

   typedef struct packed {
      logic                 en;
      logic [GRANULE_W-1:0] addr;
      link_type             data;
   } link_wr_type;

   // Class 0 holds sizes up to 16 bytes; above that the class is the bit
   // length of (granules - 1).
   function automatic logic [CLASS_W-1:0] size_class(input logic [SIZE_W-1:0] size);
      logic [SIZE_W:0] gran;
      logic [6:0]      v;
      logic [CLASS_W-1:0] c;
      gran = ({1'b0, size} + (SIZE_W+1)'(15)) >> 4;
      v    = 7'(gran - (SIZE_W+1)'(1));
      c    = '0;
      if (gran > (SIZE_W+1)'(1)) begin
         for (int i = 0; i < 7; i++) begin
            if (v[i]) begin
               c = CLASS_W'(i + 1);
            end
         end
      end
      return c;
   endfunction

endpackage

// File: hw/rtl/scfla_link_mem.sv
// Link memory of the size class allocator: one free list link per 16-byte granule.
// Depends on scfla_pkg. Synchronous write, registered read.
module scfla_link_mem
   import scfla_pkg::*;
(
   input  logic                 clock,
   input  link_wr_type          wr,
   input  logic                 rd_en,
   input  logic [GRANULE_W-1:0] rd_addr,
   output link_type             rd_data
);

   link_type link_ram [2**GRANULE_W];
   link_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         link_ram[wr.addr] <= wr.data;
      end
      if (rd_en) begin
         rd_data_ff <= link_ram[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/size_class_free_list_allocator_unit.sv
// Top level of the size class free list allocator.
// Depends on scfla_pkg and scfla_link_mem.
//
// Usage:
// Each request beat on the req_ channel is an allocate (req_func = 0) or a
// free (req_func = 1) with a byte size; sizes up to 2048 fall into eight
// power-of-two classes from 16 to 2048 bytes. Each request gives exactly one
// response beat on the rsp_ channel: address, granted size and status
// (0 ok, 1 out of arena memory, 2 size too large).
// An allocate pops the class free list if it is not empty, otherwise it
// carves the class size from a bump pointer. A free pushes the block.
// csr_wr_en writes the arena size; write it only while the block is idle.
// An accepted request moves the block to its execute state; the response is
// registered as the block leaves that state, once the output register is free.
// Requests stall meanwhile; a pop needs the link memory read to move the list head.
// Reset (synchronous) empties all lists, clears the bump pointer and sets the
// arena size to 1 MiB; the link memory itself is not cleared.
// If rsp_stall holds a response, the block finishes its current request into
// the output register as soon as it frees and stalls further requests.
module size_class_free_list_allocator_unit
   import scfla_pkg::*;
#(
   parameter int unsigned ARENA_BYTES = ARENA_DEFAULT
)
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_func,
   input  logic [SIZE_W-1:0]    req_request_size,
   input  logic [ADDR_W-1:0]    req_block_address,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [ADDR_W-1:0]    rsp_address,
   output logic [GRANT_W-1:0]   rsp_granted_size,
   output logic [1:0]           rsp_status,
   input  logic                 csr_wr_en,
   input  logic [OFFSET_W-1:0]  csr_wr_data
);

   localparam logic [OFFSET_W-1:0] LIMIT_CAP =
      (ARENA_BYTES < ADDR_SPACE) ? OFFSET_W'(ARENA_BYTES) : OFFSET_W'(ADDR_SPACE);

   state_type state_ff, state_in;

   link_type              list_heads_ff [NUM_CLASSES];
   link_type              list_heads_in [NUM_CLASSES];
   logic [OFFSET_W-1:0]   bump_offset_ff, bump_offset_in;
   logic [OFFSET_W-1:0]   arena_size_ff;

   logic                  func_ff;
   logic                  too_large_ff;
   logic [CLASS_W-1:0]    cls_ff;
   logic [GRANULE_W-1:0]  free_gran_ff;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0]     rsp_address_ff, rsp_address_in;
   logic [GRANT_W-1:0]    rsp_granted_ff, rsp_granted_in;
   status_type            rsp_status_ff, rsp_status_in;

   logic                  accept;
   logic [CLASS_W-1:0]    req_cls;
   link_type              link_rd;
   link_wr_type           link_wr;
   link_type              head_cur;
   logic [GRANT_W-1:0]    csize;
   logic [OFFSET_W:0]     bump_sum;
   logic [OFFSET_W-1:0]   limit;
   logic                  out_free;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign req_cls   = size_class(req_request_size);

   // The link of the head is read speculatively while the request is taken,
   // so a pop has its next pointer in the execute cycle.
   scfla_link_mem u_link_mem (
      .clock   (clock),
      .wr      (link_wr),
      .rd_en   (accept),
      .rd_addr (list_heads_ff[req_cls].granule),
      .rd_data (link_rd)
   );

   always_ff @(posedge clock) begin
      if (accept) begin
         func_ff      <= req_func;
         too_large_ff <= (req_request_size > SIZE_W'(MAX_SMALL));
         cls_ff       <= req_cls;
         free_gran_ff <= req_block_address[ADDR_W-1:4];
      end
      rsp_address_ff <= rsp_address_in;
      rsp_granted_ff <= rsp_granted_in;
      rsp_status_ff  <= rsp_status_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         bump_offset_ff <= '0;
         arena_size_ff  <= OFFSET_W'(ARENA_RESET);
         rsp_valid_ff   <= 1'b0;
         for (int i = 0; i < NUM_CLASSES; i++) begin
            list_heads_ff[i] <= '0;
         end
      end else begin
         state_ff       <= state_in;
         bump_offset_ff <= bump_offset_in;
         rsp_valid_ff   <= rsp_valid_in;
         list_heads_ff  <= list_heads_in;
         if (csr_wr_en) begin
            arena_size_ff <= csr_wr_data;
         end
      end
   end

   assign head_cur = list_heads_ff[cls_ff];
   assign csize    = GRANT_W'(CLASS_MIN) << cls_ff;
   assign bump_sum = {1'b0, bump_offset_ff} + (OFFSET_W+1)'(csize);
   assign limit    = (arena_size_ff < LIMIT_CAP) ? arena_size_ff : LIMIT_CAP;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in       = state_ff;
      list_heads_in  = list_heads_ff;
      bump_offset_in = bump_offset_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_address_in = rsp_address_ff;
      rsp_granted_in = rsp_granted_ff;
      rsp_status_in  = rsp_status_ff;
      link_wr        = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (out_free) begin
               state_in       = S_IDLE;
               rsp_valid_in   = 1'b1;
               rsp_address_in = '0;
               rsp_granted_in = '0;
               rsp_status_in  = ST_OK;
               if (too_large_ff) begin
                  rsp_status_in = ST_TOO_LARGE;
               end else if (func_ff == FUNC_FREE) begin
                  link_wr.en            = 1'b1;
                  link_wr.addr          = free_gran_ff;
                  link_wr.data          = head_cur;
                  list_heads_in[cls_ff] = '{valid: 1'b1, granule: free_gran_ff};
               end else if (head_cur.valid) begin
                  list_heads_in[cls_ff] = link_rd;
                  rsp_address_in        = {head_cur.granule, 4'b0000};
                  rsp_granted_in        = csize;
               end else if (bump_sum > (OFFSET_W+1)'(limit)) begin
                  rsp_status_in = ST_OUT_OF_MEM;
               end else begin
                  rsp_address_in = bump_offset_ff[ADDR_W-1:0];
                  rsp_granted_in = csize;
                  bump_offset_in = bump_sum[OFFSET_W-1:0];
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_address      = rsp_address_ff;
   assign rsp_granted_size = rsp_granted_ff;
   assign rsp_status       = rsp_status_ff;

   a_accept_to_exec: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == S_EXEC))
      else $error("accepted request did not enter execute");

   a_rsp_from_exec: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_EXEC))
      else $error("response appeared without an execute cycle");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff != ST_OK)) |->
         ((rsp_address_ff == '0) && (rsp_granted_ff == '0)))
      else $error("error response carries an address or size");

   a_bump_in_range: assert property (@(posedge clock) disable iff (reset)
      bump_offset_ff <= LIMIT_CAP)
      else $error("bump pointer beyond the arena");

endmodule
